[rtl/gaussian_pixel_charge_share_defines.svh]
// assertion macros for the gaussian pixel charge share block
`ifndef GAUSSIAN_PIXEL_CHARGE_SHARE_DEFINES_SVH
`define GAUSSIAN_PIXEL_CHARGE_SHARE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GPCS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed");
`define GPCS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed");
`else
`define GPCS_ASSERT_SAME(lbl, ante, cons)
`define GPCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/gpcs_pkg.sv]
// shared constants and erf table builder for the charge share block
`timescale 1ns / 1ps
package gpcs_pkg;
   localparam int MAX_NEIGHBORS_DEF  = 3;
   localparam int ERF_TABLE_BITS_DEF = 10;

   localparam logic [14:0] HALF_WIDTH_RST = 15'd256;
   localparam logic [15:0] INV_SIGMA_RST  = 16'd256;
   localparam logic [1:0]  NEIGHBOR_RST   = 2'd1;

   localparam logic [1:0] REG_HALF_WIDTH_Y = 2'd0;
   localparam logic [1:0] REG_HALF_WIDTH_X = 2'd1;
   localparam logic [1:0] REG_INV_SIGMA    = 2'd2;
   localparam logic [1:0] REG_NEIGHBORS    = 2'd3;

   localparam logic [15:0] ERF_ONE = 16'd32768;
   localparam logic [15:0] ONE_Q14 = 16'd16384;

   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam logic [63:0] C_A1 = 64'd75723579;
   localparam logic [63:0] C_A2 = 64'd45399965;
   localparam logic [63:0] C_A3 = 64'd9954153;
   localparam logic [63:0] C_A4 = 64'd163224;
   localparam logic [63:0] C_A5 = 64'd296962;
   localparam logic [63:0] C_A6 = 64'd46239;

   // erf of idx*4/2^bits in Q1.15, evaluated only on constants
   function automatic logic [15:0] erf_calc(input int unsigned idx, input int unsigned bits);
      logic [63:0] x;
      logic [63:0] acc;
      logic [63:0] p;
      logic [63:0] q;
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] e;
      int          i;
      x   = 64'(idx) << (32 - bits);
      acc = C_A6;
      acc = C_A5 + ((acc * x) >> 30);
      acc = C_A4 + ((acc * x) >> 30);
      acc = C_A3 + ((acc * x) >> 30);
      acc = C_A2 + ((acc * x) >> 30);
      acc = C_A1 + ((acc * x) >> 30);
      p   = ONE_Q30 + ((acc * x) >> 30);
      // rounded reciprocal in Q30 by shift and subtract
      num = (64'd1 << 60) + (p >> 1);
      rem = 64'd0;
      q   = 64'd0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= p) begin
            rem  = rem - p;
            q[i] = 1'b1;
         end
      end
      for (i = 0; i < 4; i++) begin
         q = (q * q + (64'd1 << 29)) >> 30;
      end
      if (q > ONE_Q30) begin
         q = ONE_Q30;
      end
      e = (ONE_Q30 - q + (64'd1 << 14)) >> 15;
      if (e > 64'(ERF_ONE)) begin
         e = 64'(ERF_ONE);
      end
      return e[15:0];
   endfunction
endpackage

[rtl/gpcs_erf_rom.sv]
// erf lookup table with registered read
`timescale 1ns / 1ps
module gpcs_erf_rom #(
   parameter int ERF_TABLE_BITS = gpcs_pkg::ERF_TABLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic [ERF_TABLE_BITS-1:0] addr,
   output logic [15:0]               data
);
   localparam int DEPTH = 2 ** ERF_TABLE_BITS;

   logic [15:0] rom_mem [DEPTH];
   logic [15:0] data_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_fill
      assign rom_mem[g] = gpcs_pkg::erf_calc(g, ERF_TABLE_BITS);
   end

   always_ff @(posedge clock) begin
      data_ff <= rom_mem[addr];
   end

   assign data = data_ff;
endmodule

[rtl/gpcs_mult.sv]
// shared unsigned multiplier with registered product
`timescale 1ns / 1ps
module gpcs_mult (
   input  logic        clock,
   input  logic [19:0] op_a,
   input  logic [16:0] op_b,
   output logic [36:0] prod
);
   logic [36:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= 37'(op_a) * 37'(op_b);
   end

   assign prod = prod_ff;
endmodule

[rtl/gaussian_pixel_charge_share.sv]
// top level: sequencer for gaussian charge sharing over a pixel grid
//
// channel   direction  handshake              payload
// req       in         start / busy           req_pos_y, req_pos_x
// rsp       out        rsp_valid strobe       offsets, share, sum, error, last
// csr       in         csr_valid / csr_ready  csr_index, csr_wdata
//
// an in-range hit runs each erf edge through S_EMUL, S_EIDX and S_EACC on the one
// multiplier and the erf table: first both edges of each of the 2N+1 column
// factors, then per row both edges of the row factor and S_PMUL, S_POUT per pixel
// an out-of-range hit streams all (2N+1)^2 pixels from S_ERR, one pixel a cycle
// synchronous reset clears control; results cannot be stalled
`timescale 1ns / 1ps
`include "gaussian_pixel_charge_share_defines.svh"
module gaussian_pixel_charge_share #(
   parameter int MAX_NEIGHBORS  = gpcs_pkg::MAX_NEIGHBORS_DEF,
   parameter int ERF_TABLE_BITS = gpcs_pkg::ERF_TABLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_pos_y,
   input  logic [15:0] req_pos_x,
   output logic        rsp_valid,
   output logic [2:0]  rsp_row_offset,
   output logic [2:0]  rsp_col_offset,
   output logic [15:0] rsp_share,
   output logic [15:0] rsp_share_sum,
   output logic        rsp_position_error,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int GRID = 2 * MAX_NEIGHBORS + 1;
   localparam int IW   = $clog2(GRID);
   localparam int SW   = 37 + ERF_TABLE_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EMUL = 3'd1;
   localparam logic [2:0] S_EIDX = 3'd2;
   localparam logic [2:0] S_EACC = 3'd3;
   localparam logic [2:0] S_PMUL = 3'd4;
   localparam logic [2:0] S_POUT = 3'd5;
   localparam logic [2:0] S_ERR  = 3'd6;

   // configuration
   logic [14:0] hwy_ff, hwx_ff;
   logic [15:0] k_ff;
   logic [1:0]  ncfg_ff;

   // sequencer
   logic [2:0]        state_ff, state_in;
   logic signed [15:0] py_ff, py_in, px_ff, px_in;
   logic [1:0]        n_ff, n_in;
   logic              err_ff, err_in;
   logic              axis_ff, axis_in;
   logic              hi_ff, hi_in;
   logic signed [2:0] i_ff, i_in, c_ff, c_in;
   logic              sign_ff, sign_in;
   logic              sat_ff, sat_in;
   logic signed [16:0] lo_ff, lo_in;
   logic [16:0]       colf_ff [GRID];
   logic [16:0]       rowf_ff, rowf_in;
   logic [15:0]       sum_ff, sum_in;
   logic              colf_we;

   // output registers
   logic              rv_ff, rv_in;
   logic [2:0]        rrow_ff, rrow_in, rcol_ff, rcol_in;
   logic [15:0]       rshare_ff, rshare_in, rsum_ff;
   logic              rerr_ff, rerr_in, rlast_ff, rlast_in;

   // datapath
   logic [19:0]              mul_a;
   logic [16:0]              mul_b;
   logic [36:0]              prod;
   logic [ERF_TABLE_BITS-1:0] rom_addr;
   logic [15:0]              rom_data;

   logic signed [2:0]  n_s;
   logic [1:0]         ai;
   logic [16:0]        w_ext, mag_iw;
   logic signed [21:0] p_ext, iw, off, span;
   logic [19:0]        mag;
   logic [SW-1:0]      scaled;
   logic [IW-1:0]      c_idx;
   logic [3:0]         c_sum;
   logic [16:0]        erf_v;
   logic signed [16:0] erf_s;
   logic signed [17:0] diff;
   logic [16:0]        fac;
   logic [19:0]        rounded;
   logic [15:0]        share;
   logic [16:0]        sum_wide;
   logic [1:0]         n_eff;
   logic [17:0]        lim_y, lim_x;
   logic               err_now;
   logic               err_off_centre;

   gpcs_mult u_mult (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   gpcs_erf_rom #(.ERF_TABLE_BITS(ERF_TABLE_BITS)) u_rom (
      .clock (clock),
      .addr  (rom_addr),
      .data  (rom_data)
   );

   // registers only change between items
   assign csr_ready = !busy && !start;
   assign busy      = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         hwy_ff  <= gpcs_pkg::HALF_WIDTH_RST;
         hwx_ff  <= gpcs_pkg::HALF_WIDTH_RST;
         k_ff    <= gpcs_pkg::INV_SIGMA_RST;
         ncfg_ff <= gpcs_pkg::NEIGHBOR_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gpcs_pkg::REG_HALF_WIDTH_Y: hwy_ff  <= csr_wdata[14:0];
            gpcs_pkg::REG_HALF_WIDTH_X: hwx_ff  <= csr_wdata[14:0];
            gpcs_pkg::REG_INV_SIGMA:    k_ff    <= csr_wdata;
            gpcs_pkg::REG_NEIGHBORS:    ncfg_ff <= csr_wdata[1:0];
            default:                    k_ff    <= k_ff;
         endcase
      end
   end

   // start-time decode
   always_comb begin
      if (ncfg_ff == 2'd0) begin
         n_eff = 2'd1;
      end else if (32'(ncfg_ff) > MAX_NEIGHBORS) begin
         n_eff = 2'(MAX_NEIGHBORS);
      end else begin
         n_eff = ncfg_ff;
      end
      lim_y   = 18'({hwy_ff, 1'b0}) + 18'(hwy_ff);
      lim_x   = 18'({hwx_ff, 1'b0}) + 18'(hwx_ff);
      err_now = ($signed(18'(signed'(req_pos_y))) > $signed(lim_y))
             || ($signed(18'(signed'(req_pos_y))) < -$signed(lim_y))
             || ($signed(18'(signed'(req_pos_x))) > $signed(lim_x))
             || ($signed(18'(signed'(req_pos_x))) < -$signed(lim_x));
   end

   // edge distance: P - (4i -/+ 2)w
   always_comb begin
      n_s    = signed'({1'b0, n_ff});
      w_ext  = axis_ff ? 17'(hwy_ff) : 17'(hwx_ff);
      p_ext  = axis_ff ? 22'(py_ff) : 22'(px_ff);
      ai     = i_ff[2] ? 2'(-i_ff) : i_ff[1:0];
      mag_iw = (ai[1] ? {w_ext[15:0], 1'b0} : 17'd0) + (ai[0] ? w_ext : 17'd0);
      iw     = i_ff[2] ? -signed'(22'(mag_iw)) : signed'(22'(mag_iw));
      off    = hi_ff ? (iw <<< 2) + signed'(22'({w_ext, 1'b0}))
                     : (iw <<< 2) - signed'(22'({w_ext, 1'b0}));
      span   = p_ext - off;
      mag    = span[21] ? 20'(-span) : 20'(span);
      c_sum  = 4'(c_ff) + 4'(n_ff);
      c_idx  = IW'(c_sum);
      if (state_ff == S_PMUL) begin
         mul_a = 20'(rowf_ff);
         mul_b = colf_ff[c_idx];
      end else begin
         mul_a = mag;
         mul_b = 17'(k_ff);
      end
      scaled   = ((SW'(prod) << ERF_TABLE_BITS) + SW'(1024)) >> 11;
      rom_addr = scaled[ERF_TABLE_BITS-1:0];
      erf_v    = sat_ff ? 17'(gpcs_pkg::ERF_ONE) : 17'(rom_data);
      erf_s    = sign_ff ? -signed'(erf_v) : signed'(erf_v);
      diff     = 18'(lo_ff) - 18'(erf_s);
      if (diff[17]) begin
         fac = 17'd0;
      end else if (diff > 18'sd65536) begin
         fac = 17'd65536;
      end else begin
         fac = diff[16:0];
      end
      rounded = 20'((prod + 37'(1 << 17)) >> 18);
      share   = (rounded > 20'd65535) ? 16'hFFFF : rounded[15:0];
   end

   always_comb begin
      state_in  = state_ff;
      py_in     = py_ff;
      px_in     = px_ff;
      n_in      = n_ff;
      err_in    = err_ff;
      axis_in   = axis_ff;
      hi_in     = hi_ff;
      i_in      = i_ff;
      c_in      = c_ff;
      sign_in   = sign_ff;
      sat_in    = sat_ff;
      lo_in     = lo_ff;
      rowf_in   = rowf_ff;
      sum_in    = sum_ff;
      colf_we   = 1'b0;
      rv_in     = 1'b0;
      rrow_in   = rrow_ff;
      rcol_in   = rcol_ff;
      rshare_in = rshare_ff;
      rerr_in   = rerr_ff;
      rlast_in  = 1'b0;
      sum_wide  = 17'(sum_ff);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               py_in   = signed'(req_pos_y);
               px_in   = signed'(req_pos_x);
               n_in    = n_eff;
               err_in  = err_now;
               axis_in = 1'b0;
               hi_in   = 1'b0;
               i_in    = -signed'({1'b0, n_eff});
               c_in    = -signed'({1'b0, n_eff});
               sum_in  = 16'd0;
               state_in = err_now ? S_ERR : S_EMUL;
            end
         end
         S_EMUL: begin
            sign_in  = span[21];
            state_in = S_EIDX;
         end
         S_EIDX: begin
            sat_in   = |scaled[SW-1:ERF_TABLE_BITS];
            state_in = S_EACC;
         end
         S_EACC: begin
            if (!hi_ff) begin
               lo_in    = erf_s;
               hi_in    = 1'b1;
               state_in = S_EMUL;
            end else begin
               hi_in = 1'b0;
               if (!axis_ff) begin
                  colf_we = 1'b1;
                  if (i_ff == n_s) begin
                     axis_in = 1'b1;
                     i_in    = -n_s;
                  end else begin
                     i_in = i_ff + 3'sd1;
                  end
                  state_in = S_EMUL;
               end else begin
                  rowf_in  = fac;
                  c_in     = -n_s;
                  state_in = S_PMUL;
               end
            end
         end
         S_PMUL: begin
            state_in = S_POUT;
         end
         S_POUT, S_ERR: begin
            if (state_ff == S_ERR) begin
               rshare_in = (i_ff == 3'sd0 && c_ff == 3'sd0) ? gpcs_pkg::ONE_Q14 : 16'd0;
            end else begin
               rshare_in = share;
            end
            sum_wide = 17'(sum_ff) + 17'(rshare_in);
            sum_in   = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
            rv_in    = 1'b1;
            rrow_in  = i_ff;
            rcol_in  = c_ff;
            rerr_in  = err_ff;
            rlast_in = (i_ff == n_s) && (c_ff == n_s);
            if (c_ff == n_s) begin
               c_in = -n_s;
               if (i_ff == n_s) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 3'sd1;
                  state_in = (state_ff == S_ERR) ? S_ERR : S_EMUL;
               end
            end else begin
               c_in     = c_ff + 3'sd1;
               state_in = (state_ff == S_ERR) ? S_ERR : S_PMUL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
         rlast_ff <= 1'b0;
         rowf_ff  <= 17'd0;
         sum_ff   <= 16'd0;
         i_ff     <= 3'sd0;
         c_ff     <= 3'sd0;
         py_ff    <= 16'sd0;
         px_ff    <= 16'sd0;
         hi_ff    <= 1'b0;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         rlast_ff <= rlast_in;
         rowf_ff  <= rowf_in;
         sum_ff   <= sum_in;
         i_ff     <= i_in;
         c_ff     <= c_in;
         py_ff    <= py_in;
         px_ff    <= px_in;
         hi_ff    <= hi_in;
         axis_ff  <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      err_ff    <= err_in;
      sign_ff   <= sign_in;
      sat_ff    <= sat_in;
      lo_ff     <= lo_in;
      rrow_ff   <= rrow_in;
      rcol_ff   <= rcol_in;
      rshare_ff <= rshare_in;
      rsum_ff   <= sum_in;
      rerr_ff   <= rerr_in;
      if (colf_we) begin
         colf_ff[IW'(4'(i_ff) + 4'(n_ff))] <= fac;
      end
   end

   assign rsp_valid          = rv_ff;
   assign rsp_row_offset     = rrow_ff;
   assign rsp_col_offset     = rcol_ff;
   assign rsp_share          = rshare_ff;
   assign rsp_share_sum      = rsum_ff;
   assign rsp_position_error = rerr_ff;
   assign rsp_last           = rlast_ff;

   assign err_off_centre = rsp_valid && rsp_position_error
                        && !(rsp_row_offset == 3'd0 && rsp_col_offset == 3'd0);

   `GPCS_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy)
   `GPCS_ASSERT_NEXT(a_last_ends_burst, rsp_valid && rsp_last, !rsp_valid)
   `GPCS_ASSERT_SAME(a_err_off_centre_zero, err_off_centre, rsp_share == 16'd0)
   `GPCS_ASSERT_SAME(a_sum_covers_share, rsp_valid, rsp_share_sum >= rsp_share)
endmodule
